// File: rtl/core/csvp_pkg.sv
// Shared types and constants for the CSV dialect character parser.
// Depends on nothing; the parser, configuration, step and checker files import it.
package csvp_pkg;

   localparam int unsigned STATE_BITS = 4;
   localparam int unsigned ACT_BITS   = 2;
   localparam int unsigned IDX_BITS   = 3;

   typedef logic [STATE_BITS-1:0] state_type;
   typedef logic [ACT_BITS-1:0]   action_type;
   typedef logic [IDX_BITS-1:0]   csr_index_type;

   localparam state_type S_REC  = 4'd0;
   localparam state_type S_FLD  = 4'd1;
   localparam state_type S_ESC  = 4'd2;
   localparam state_type S_AEN  = 4'd3;
   localparam state_type S_IN   = 4'd4;
   localparam state_type S_QIN  = 4'd5;
   localparam state_type S_QESC = 4'd6;
   localparam state_type S_QQ   = 4'd7;
   localparam state_type S_NL   = 4'd8;

   localparam action_type ACT_CHAR  = 2'd0;
   localparam action_type ACT_END   = 2'd1;
   localparam action_type ACT_ERROR = 2'd2;

   localparam csr_index_type REG_DELIMITER  = 3'd0;
   localparam csr_index_type REG_QUOTE      = 3'd1;
   localparam csr_index_type REG_ESCAPE     = 3'd2;
   localparam csr_index_type REG_ESC_ENABLE = 3'd3;
   localparam csr_index_type REG_QUOTING    = 3'd4;
   localparam csr_index_type REG_DBL_QUOTE  = 3'd5;
   localparam csr_index_type REG_SKIP_SPACE = 3'd6;
   localparam csr_index_type REG_STRICT     = 3'd7;

   localparam logic [1:0] QMODE_NONE = 2'd3;

   localparam logic [31:0] EOL_MARK  = 32'h0000_FFFE;
   localparam logic [31:0] CH_LF     = 32'h0000_000A;
   localparam logic [31:0] CH_CR     = 32'h0000_000D;
   localparam logic [31:0] CH_SP     = 32'h0000_0020;
   localparam logic [31:0] OUT_MASK  = 32'h0000_FFFF;

   localparam logic [31:0] RST_DELIMITER = 32'd44;
   localparam logic [31:0] RST_QUOTE     = 32'd34;
   localparam logic [31:0] RST_ESCAPE    = 32'd92;

   typedef struct packed {
      logic       escape_enable;
      logic [1:0] quoting_mode;
      logic       double_quote;
      logic       skip_initial_space;
      logic       strict_mode;
   } flags_type;

endpackage

// File: rtl/core/csvp_if.sv
// Valid/ready channel interfaces for the parser's item and result streams.
// Depends on nothing but the CHAR_BITS parameter passed by the instantiating level.
interface csvp_req_if #(parameter int unsigned CHAR_BITS = 16);
   logic                 valid;
   logic                 ready;
   logic [CHAR_BITS-1:0] code_unit;

   modport source (output valid, output code_unit, input ready);
   modport sink   (input valid, input code_unit, output ready);
endinterface

interface csvp_rsp_if #(parameter int unsigned CHAR_BITS = 16);
   logic                 valid;
   logic                 ready;
   logic [1:0]           action;
   logic [CHAR_BITS-1:0] out_char;
   logic                 line_break_end;

   modport source (output valid, output action, output out_char, output line_break_end,
                   input ready);
   modport sink   (input valid, input action, input out_char, input line_break_end,
                   output ready);
endinterface

// File: rtl/core/csv_dialect_char_parser.sv
// CSV dialect character parser: two register stages, the input register and the result
// register. Throughput one item per cycle unless results stall; the parser state register
// closes a loop. Items that end no field and append nothing produce no result.
// Synchronous active-high reset returns the parser to start of record and the
// dialect registers to comma, double quote, backslash, escape off, minimal quoting.
module csv_dialect_char_parser #(
   parameter int unsigned CHAR_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   csvp_req_if.sink                req_if,
   csvp_rsp_if.source              rsp_if,
   input  logic                    csr_write_enable,
   input  csvp_pkg::csr_index_type csr_index,
   input  logic [CHAR_BITS-1:0]    csr_write_data
);
   import csvp_pkg::*;

   logic [CHAR_BITS-1:0] delimiter_char;
   logic [CHAR_BITS-1:0] quote_char;
   logic [CHAR_BITS-1:0] escape_char;
   flags_type            flags;

   logic                 in_vld_ff;
   logic [CHAR_BITS-1:0] in_char_ff;
   state_type            state_ff;
   logic                 out_vld_ff;
   action_type           out_act_ff;
   logic [CHAR_BITS-1:0] out_char_ff;
   logic                 out_lb_ff;

   state_type            state_in;
   logic                 has_result;
   action_type           act_in;
   logic [CHAR_BITS-1:0] char_in;
   logic                 lb_in;
   logic                 advance;
   logic                 accept;

   csvp_cfg #(.CHAR_BITS(CHAR_BITS)) u_cfg (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .delimiter_char   (delimiter_char),
      .quote_char       (quote_char),
      .escape_char      (escape_char),
      .flags            (flags)
   );

   csvp_step #(.CHAR_BITS(CHAR_BITS)) u_step (
      .state          (state_ff),
      .code_unit      (in_char_ff),
      .delimiter_char (delimiter_char),
      .quote_char     (quote_char),
      .escape_char    (escape_char),
      .flags          (flags),
      .next_state     (state_in),
      .has_result     (has_result),
      .action         (act_in),
      .out_char       (char_in),
      .line_break_end (lb_in)
   );

   assign advance       = in_vld_ff && (!out_vld_ff || rsp_if.ready);
   assign req_if.ready  = !in_vld_ff || advance;
   assign accept        = req_if.valid && req_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         state_ff   <= S_REC;
         out_vld_ff <= 1'b0;
      end else begin
         if (req_if.ready) begin
            in_vld_ff <= req_if.valid;
         end
         if (advance) begin
            state_ff   <= state_in;
            out_vld_ff <= has_result;
         end else if (rsp_if.ready) begin
            out_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_char_ff <= req_if.code_unit;
      end
      if (advance) begin
         out_act_ff  <= act_in;
         out_char_ff <= char_in;
         out_lb_ff   <= lb_in;
      end
   end

   assign rsp_if.valid          = out_vld_ff;
   assign rsp_if.action         = out_act_ff;
   assign rsp_if.out_char       = out_char_ff;
   assign rsp_if.line_break_end = out_lb_ff;

endmodule

// File: rtl/core/csvp_cfg.sv
// Dialect register file written through the plain configuration port.
// Depends on csvp_pkg for register indexes, reset values and the flag struct.
module csvp_cfg #(
   parameter int unsigned CHAR_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_enable,
   input  csvp_pkg::csr_index_type   csr_index,
   input  logic [CHAR_BITS-1:0]      csr_write_data,
   output logic [CHAR_BITS-1:0]      delimiter_char,
   output logic [CHAR_BITS-1:0]      quote_char,
   output logic [CHAR_BITS-1:0]      escape_char,
   output csvp_pkg::flags_type       flags
);
   import csvp_pkg::*;

   logic [CHAR_BITS-1:0] delim_ff;
   logic [CHAR_BITS-1:0] quote_ff;
   logic [CHAR_BITS-1:0] escape_ff;
   flags_type            flags_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         delim_ff                    <= CHAR_BITS'(RST_DELIMITER);
         quote_ff                    <= CHAR_BITS'(RST_QUOTE);
         escape_ff                   <= CHAR_BITS'(RST_ESCAPE);
         flags_ff.escape_enable      <= 1'b0;
         flags_ff.quoting_mode       <= 2'd0;
         flags_ff.double_quote       <= 1'b1;
         flags_ff.skip_initial_space <= 1'b0;
         flags_ff.strict_mode        <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_DELIMITER:  delim_ff                    <= csr_write_data;
            REG_QUOTE:      quote_ff                    <= csr_write_data;
            REG_ESCAPE:     escape_ff                   <= csr_write_data;
            REG_ESC_ENABLE: flags_ff.escape_enable      <= csr_write_data[0];
            REG_QUOTING:    flags_ff.quoting_mode       <= csr_write_data[1:0];
            REG_DBL_QUOTE:  flags_ff.double_quote       <= csr_write_data[0];
            REG_SKIP_SPACE: flags_ff.skip_initial_space <= csr_write_data[0];
            REG_STRICT:     flags_ff.strict_mode        <= csr_write_data[0];
            default:        flags_ff                    <= flags_ff;
         endcase
      end
   end

   assign delimiter_char = delim_ff;
   assign quote_char     = quote_ff;
   assign escape_char    = escape_ff;
   assign flags          = flags_ff;

endmodule

// File: rtl/core/csvp_step.sv
// Next-state and action logic of the nine-state field parser for one item.
// Depends on csvp_pkg for state codes, action codes and character constants.
module csvp_step #(
   parameter int unsigned CHAR_BITS = 16
) (
   input  csvp_pkg::state_type       state,
   input  logic [CHAR_BITS-1:0]      code_unit,
   input  logic [CHAR_BITS-1:0]      delimiter_char,
   input  logic [CHAR_BITS-1:0]      quote_char,
   input  logic [CHAR_BITS-1:0]      escape_char,
   input  csvp_pkg::flags_type       flags,
   output csvp_pkg::state_type       next_state,
   output logic                      has_result,
   output csvp_pkg::action_type      action,
   output logic [CHAR_BITS-1:0]      out_char,
   output logic                      line_break_end
);
   import csvp_pkg::*;

   logic [31:0]          c_wide;
   logic                 is_eol;
   logic                 is_nl;
   logic                 is_brk;
   logic                 is_quote;
   logic                 is_esc;
   logic                 is_delim;
   logic                 is_space;
   state_type            eff_state;
   logic [CHAR_BITS-1:0] chr;
   logic [CHAR_BITS-1:0] chr_or_lf;

   assign c_wide    = 32'(code_unit);
   assign is_eol    = (c_wide == EOL_MARK);
   assign is_nl     = (c_wide == CH_LF) || (c_wide == CH_CR);
   assign is_brk    = is_nl || is_eol;
   assign is_quote  = (flags.quoting_mode != QMODE_NONE) && (code_unit == quote_char);
   assign is_esc    = flags.escape_enable && (code_unit == escape_char);
   assign is_delim  = (code_unit == delimiter_char);
   assign is_space  = (c_wide == CH_SP);
   assign chr_or_lf = is_eol ? CHAR_BITS'(CH_LF) : code_unit;

   always_comb begin
      eff_state = (state > S_NL) ? S_REC : state;
      if ((eff_state == S_REC) && !is_brk) begin
         eff_state = S_FLD;
      end
      if ((eff_state == S_AEN) && !is_eol) begin
         eff_state = S_IN;
      end

      next_state     = eff_state;
      has_result     = 1'b0;
      action         = ACT_CHAR;
      chr            = code_unit;
      line_break_end = 1'b0;

      unique case (eff_state)
         S_REC: begin
            next_state = is_eol ? S_REC : S_NL;
         end
         S_AEN: begin
            next_state = S_AEN;
         end
         S_FLD: begin
            priority if (is_brk) begin
               next_state     = is_eol ? S_REC : S_NL;
               has_result     = 1'b1;
               action         = ACT_END;
               line_break_end = 1'b1;
            end else if (is_quote) begin
               next_state = S_QIN;
            end else if (is_esc) begin
               next_state = S_ESC;
            end else if (is_space && flags.skip_initial_space) begin
               next_state = S_FLD;
            end else if (is_delim) begin
               next_state = S_FLD;
               has_result = 1'b1;
               action     = ACT_END;
            end else begin
               next_state = S_IN;
               has_result = 1'b1;
            end
         end
         S_ESC: begin
            has_result = 1'b1;
            if (is_nl) begin
               next_state = S_AEN;
            end else begin
               next_state = S_IN;
               chr        = chr_or_lf;
            end
         end
         S_IN: begin
            priority if (is_brk) begin
               next_state     = is_eol ? S_REC : S_NL;
               has_result     = 1'b1;
               action         = ACT_END;
               line_break_end = 1'b1;
            end else if (is_esc) begin
               next_state = S_ESC;
            end else if (is_delim) begin
               next_state = S_FLD;
               has_result = 1'b1;
               action     = ACT_END;
            end else begin
               next_state = S_IN;
               has_result = 1'b1;
            end
         end
         S_QIN: begin
            priority if (is_eol) begin
               next_state = S_QIN;
            end else if (is_esc) begin
               next_state = S_QESC;
            end else if (is_quote) begin
               next_state = flags.double_quote ? S_QQ : S_IN;
            end else begin
               next_state = S_QIN;
               has_result = 1'b1;
            end
         end
         S_QESC: begin
            next_state = S_QIN;
            has_result = 1'b1;
            chr        = chr_or_lf;
         end
         S_QQ: begin
            has_result = 1'b1;
            priority if (is_quote) begin
               next_state = S_QIN;
            end else if (is_delim) begin
               next_state = S_FLD;
               action     = ACT_END;
            end else if (is_brk) begin
               next_state     = is_eol ? S_REC : S_NL;
               action         = ACT_END;
               line_break_end = 1'b1;
            end else if (!flags.strict_mode) begin
               next_state = S_IN;
            end else begin
               next_state = S_QQ;
               action     = ACT_ERROR;
            end
         end
         S_NL: begin
            priority if (is_nl) begin
               next_state = S_NL;
            end else if (is_eol) begin
               next_state = S_REC;
            end else begin
               next_state = S_NL;
               has_result = 1'b1;
               action     = ACT_ERROR;
            end
         end
         default: begin
            next_state = S_REC;
         end
      endcase

      out_char = (action == ACT_CHAR) ? CHAR_BITS'(32'(chr) & OUT_MASK) : '0;
   end

endmodule

// File: rtl/core/csvp_checker.sv
// Port-level assertions for the CSV dialect character parser.
// Depends on csvp_pkg for action codes; bound to the top level below.
module csvp_checker #(
   parameter int unsigned CHAR_BITS = 16
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [1:0]           rsp_action,
   input logic [CHAR_BITS-1:0] rsp_out_char,
   input logic                 rsp_line_break_end
);
   import csvp_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_action)
         && $stable(rsp_out_char) && $stable(rsp_line_break_end))
      else $error("Stalled result item changed.");

   a_char_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_action != ACT_CHAR) |-> (rsp_out_char == '0))
      else $error("Non-character result item carries a character.");

   a_break_only_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_line_break_end |-> (rsp_action == ACT_END))
      else $error("Line break flag set on a result item that ends no field.");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("Result item shown right after reset.");

endmodule

bind csv_dialect_char_parser csvp_checker #(.CHAR_BITS(CHAR_BITS)) u_csvp_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_if.valid),
   .rsp_ready          (rsp_if.ready),
   .rsp_action         (rsp_if.action),
   .rsp_out_char       (rsp_if.out_char),
   .rsp_line_break_end (rsp_if.line_break_end)
);
